[rtl/ngh_pkg.sv]
// ----------------------------------------------------------------------------
// ngh_pkg
// Shared types and register map of the sidechain noise gate.
// ----------------------------------------------------------------------------
package ngh_pkg;

    localparam int NUM_REGS   = 7;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GATE_ENABLE  = 3'd0,
        REG_HP_COEFF     = 3'd1,
        REG_LP_COEFF     = 3'd2,
        REG_ENV_ATTACK   = 3'd3,
        REG_ENV_RELEASE  = 3'd4,
        REG_GAIN_ATTACK  = 3'd5,
        REG_GAIN_RELEASE = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPER,
        ST_MUL,
        ST_APPLY,
        ST_DONE
    } t_state;

    // one entry per pass through the shared multiplier
    typedef enum logic [2:0] {
        STEP_HL,
        STEP_LP,
        STEP_ENV,
        STEP_GAIN,
        STEP_OUT
    } t_step;

endpackage

[rtl/noise_gate_hysteresis.sv]
// ----------------------------------------------------------------------------
// noise_gate_hysteresis
// Sidechain-detected noise gate with hysteresis and smoothed gain.
//
// Input channel (i_in_valid / o_in_ready) takes one item: a sidechain sample
// and an audio sample. Output channel (o_out_valid / i_out_ready) returns the
// gated sample and the hysteresis flag. Coefficients and the enable bit sit in an
// APB register file, written by the user only while idle; the block does not enforce it.
// One multiplier is shared over five passes per item: high-pass low part,
// sidechain low-pass, envelope, gain smoothing and the final audio scaling.
// Each pass runs through operand setup, multiply and accumulate (OPER, MUL,
// APPLY), and an enabled item reaches DONE after its last pass; a bypassed
// item (gate disabled) goes from acceptance straight to DONE. No new item is
// taken until the current one has left DONE.
// o_in_ready is high only between items.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished item holds in the last step
// until the output register frees.
// Reset (synchronous, active low) restores the default coefficients, clears
// the filter, envelope and gain state and closes the gate.
// ----------------------------------------------------------------------------
module noise_gate_hysteresis #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sidechain_sample,
    input  logic signed [SAMPLE_BITS-1:0]       i_audio_sample,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_gated_sample,
    output logic                                o_gate_open,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ngh_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int S  = SAMPLE_BITS;
    localparam int C  = COEFF_BITS;
    localparam int MW = (S + 2 > C + 1) ? S + 2 : C + 1;  // multiplier magnitude width
    localparam int DW = MW + 1;                           // signed datapath width
    localparam int PW = C + 1 + MW;                       // full product width

    localparam logic [63:0] HALF_SCALE  = 64'd1 << (S - 1);
    localparam logic [63:0] THR_OPEN_W  = (HALF_SCALE + 64'd500) / 64'd1000;
    localparam logic [63:0] THR_CLOSE_W = (HALF_SCALE * 64'd9 + 64'd10000) / 64'd20000;
    localparam logic [S-1:0] THR_OPEN   = THR_OPEN_W[S-1:0];
    localparam logic [S-1:0] THR_CLOSE  = THR_CLOSE_W[S-1:0];
    localparam logic [C:0]   UNITY      = {1'b1, {C{1'b0}}};
    localparam logic [PW-1:0] RND       = PW'(1) << (C - 1);

    // ---------------- register file ----------------
    logic         r_enable;
    logic [C-1:0] r_hp_coeff;
    logic [C-1:0] r_lp_coeff;
    logic [C-1:0] r_env_attack;
    logic [C-1:0] r_env_release;
    logic [C-1:0] r_gain_attack;
    logic [C-1:0] r_gain_release;

    logic             w_cfg_wr;
    ngh_pkg::t_reg_idx w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = ngh_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_hp_coeff     <= C'(216765);
            r_lp_coeff     <= C'(4952960);
            r_env_attack   <= C'(231405);
            r_env_release  <= C'(1589);
            r_gain_attack  <= C'(345890);
            r_gain_release <= C'(1942);
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                ngh_pkg::REG_GATE_ENABLE:  r_enable       <= pwdata[0];
                ngh_pkg::REG_HP_COEFF:     r_hp_coeff     <= pwdata[C-1:0];
                ngh_pkg::REG_LP_COEFF:     r_lp_coeff     <= pwdata[C-1:0];
                ngh_pkg::REG_ENV_ATTACK:   r_env_attack   <= pwdata[C-1:0];
                ngh_pkg::REG_ENV_RELEASE:  r_env_release  <= pwdata[C-1:0];
                ngh_pkg::REG_GAIN_ATTACK:  r_gain_attack  <= pwdata[C-1:0];
                ngh_pkg::REG_GAIN_RELEASE: r_gain_release <= pwdata[C-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            ngh_pkg::REG_GATE_ENABLE:  prdata = {31'd0, r_enable};
            ngh_pkg::REG_HP_COEFF:     prdata = 32'(r_hp_coeff);
            ngh_pkg::REG_LP_COEFF:     prdata = 32'(r_lp_coeff);
            ngh_pkg::REG_ENV_ATTACK:   prdata = 32'(r_env_attack);
            ngh_pkg::REG_ENV_RELEASE:  prdata = 32'(r_env_release);
            ngh_pkg::REG_GAIN_ATTACK:  prdata = 32'(r_gain_attack);
            ngh_pkg::REG_GAIN_RELEASE: prdata = 32'(r_gain_release);
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    ngh_pkg::t_state r_state, n_state;
    ngh_pkg::t_step  r_step;

    logic w_in_acc;
    logic w_out_free;

    assign o_in_ready = (r_state == ngh_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ngh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ngh_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_enable ? ngh_pkg::ST_OPER : ngh_pkg::ST_DONE;
                end
            end
            ngh_pkg::ST_OPER:  n_state = ngh_pkg::ST_MUL;
            ngh_pkg::ST_MUL:   n_state = ngh_pkg::ST_APPLY;
            ngh_pkg::ST_APPLY: begin
                n_state = (r_step == ngh_pkg::STEP_OUT) ? ngh_pkg::ST_DONE : ngh_pkg::ST_OPER;
            end
            ngh_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ngh_pkg::ST_IDLE;
                end
            end
            default: n_state = ngh_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    logic signed [S-1:0]   r_sc;
    logic signed [S-1:0]   r_audio;
    logic signed [S-1:0]   r_hl;      // low part of the high-pass
    logic signed [S+1:0]   r_lp;      // sidechain low-pass, two guard bits
    logic        [S-1:0]   r_env;
    logic        [C:0]     r_gain;
    logic                  r_flag;
    logic        [C:0]     r_ma;
    logic        [MW-1:0]  r_mb;
    logic                  r_neg;
    logic        [MW-1:0]  r_prod;
    logic signed [S-1:0]   r_res;

    logic signed [DW-1:0]  w_hpv;
    logic        [S+1:0]   w_lp_abs;
    logic        [S-1:0]   w_mag;
    logic                  w_flag;
    logic signed [DW-1:0]  w_diff;
    logic        [C:0]     w_coef;
    logic        [PW-1:0]  w_prod;
    logic signed [DW-1:0]  w_sval;
    logic signed [DW-1:0]  w_base;
    logic signed [DW-1:0]  w_sum;

    assign w_hpv    = DW'(r_sc) - DW'(r_hl);
    assign w_lp_abs = r_lp[S+1] ? (S+2)'(-r_lp) : r_lp;
    // magnitude saturates at full unsigned scale
    assign w_mag    = (w_lp_abs[S+1:S] != 2'b00) ? {S{1'b1}} : w_lp_abs[S-1:0];
    assign w_flag   = r_flag ? !(r_env < THR_CLOSE) : (r_env >= THR_OPEN);

    // operand selection for the current pass
    always_comb begin
        case (r_step)
            ngh_pkg::STEP_HL: begin
                w_diff = DW'(r_sc) - DW'(r_hl);
                w_coef = {1'b0, r_hp_coeff};
            end
            ngh_pkg::STEP_LP: begin
                w_diff = w_hpv - DW'(r_lp);
                w_coef = {1'b0, r_lp_coeff};
            end
            ngh_pkg::STEP_ENV: begin
                w_diff = DW'($signed({1'b0, w_mag})) - DW'($signed({1'b0, r_env}));
                w_coef = (w_mag > r_env) ? {1'b0, r_env_attack} : {1'b0, r_env_release};
            end
            ngh_pkg::STEP_GAIN: begin
                w_diff = (w_flag ? DW'($signed({1'b0, UNITY})) : DW'(0))
                       - DW'($signed({1'b0, r_gain}));
                w_coef = (w_flag && (r_gain < UNITY)) ? {1'b0, r_gain_attack}
                                                      : {1'b0, r_gain_release};
            end
            ngh_pkg::STEP_OUT: begin
                w_diff = DW'(r_audio);
                w_coef = r_gain;
            end
            default: begin
                w_diff = '0;
                w_coef = '0;
            end
        endcase
    end

    // rounded product, ties away from zero after the sign is restored
    assign w_prod = PW'(r_ma) * PW'(r_mb) + RND;
    assign w_sval = r_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});

    always_comb begin
        case (r_step)
            ngh_pkg::STEP_HL:   w_base = DW'(r_hl);
            ngh_pkg::STEP_LP:   w_base = DW'(r_lp);
            ngh_pkg::STEP_ENV:  w_base = DW'($signed({1'b0, r_env}));
            ngh_pkg::STEP_GAIN: w_base = DW'($signed({1'b0, r_gain}));
            default:            w_base = '0;
        endcase
    end

    assign w_sum = w_base + w_sval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ngh_pkg::STEP_HL;
            r_hl   <= '0;
            r_lp   <= '0;
            r_env  <= '0;
            r_gain <= '0;
            r_flag <= 1'b0;
        end else begin
            case (r_state)
                ngh_pkg::ST_IDLE: begin
                    r_step <= ngh_pkg::STEP_HL;
                    if (w_in_acc) begin
                        r_sc    <= i_sidechain_sample;
                        r_audio <= i_audio_sample;
                        r_res   <= i_audio_sample;   // bypass value
                    end
                end
                ngh_pkg::ST_OPER: begin
                    r_ma  <= w_coef;
                    r_mb  <= w_diff[DW-1] ? MW'(-w_diff) : MW'(w_diff);
                    r_neg <= w_diff[DW-1];
                    if (r_step == ngh_pkg::STEP_GAIN) begin
                        r_flag <= w_flag;
                    end
                end
                ngh_pkg::ST_MUL: begin
                    r_prod <= w_prod[C +: MW];
                end
                ngh_pkg::ST_APPLY: begin
                    case (r_step)
                        ngh_pkg::STEP_HL: begin
                            r_hl   <= w_sum[S-1:0];
                            r_step <= ngh_pkg::STEP_LP;
                        end
                        ngh_pkg::STEP_LP: begin
                            r_lp   <= w_sum[S+1:0];
                            r_step <= ngh_pkg::STEP_ENV;
                        end
                        ngh_pkg::STEP_ENV: begin
                            r_env  <= w_sum[S-1:0];
                            r_step <= ngh_pkg::STEP_GAIN;
                        end
                        ngh_pkg::STEP_GAIN: begin
                            r_gain <= w_sum[C:0];
                            r_step <= ngh_pkg::STEP_OUT;
                        end
                        ngh_pkg::STEP_OUT: begin
                            r_res  <= w_sum[S-1:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ngh_pkg::ST_DONE && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ngh_pkg::ST_DONE && w_out_free) begin
            o_gated_sample <= r_res;
            o_gate_open    <= r_flag;
        end
    end

endmodule

[dv/noise_gate_hysteresis_test.sv]
// ----------------------------------------------------------------------------
// noise_gate_hysteresis_test
// Self-checking bench for the sidechain noise gate. A clocked driver feeds
// items from a pending queue, a clocked monitor checks every result against
// a bit-exact software copy of the detector, envelope, hysteresis and gain
// path. Config is reprogrammed over APB between phases and read back.
// ----------------------------------------------------------------------------
module noise_gate_hysteresis_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 24;
    localparam int CB = 24;
    localparam int AW = ngh_pkg::CFG_ADDR_W;
    localparam longint SMASK = (longint'(1) << SB) - 1;
    localparam longint UNITY = longint'(1) << CB;
    localparam longint HALF_SCALE = longint'(1) << (SB - 1);
    localparam longint THR_OPEN = (HALF_SCALE + 500) / 1000;
    localparam longint THR_CLOSE = (HALF_SCALE * 9 + 10000) / 20000;
    localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [SB-1:0] sc;
        logic signed [SB-1:0] audio;
    } t_gate_in;

    typedef struct packed {
        logic signed [SB-1:0] gated;
        logic                 is_open;
    } t_gated;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [SB-1:0] i_sidechain_sample = '0;
    logic signed [SB-1:0] i_audio_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [SB-1:0] o_gated_sample;
    logic                 o_gate_open;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AW-1:0]        paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_gate_in item_q[$];
    t_gated   gated_fifo[$];
    int       mismatches = 0;
    bit       in_gaps_on = 1'b1;
    bit       out_gaps_on = 1'b1;
    bit       hold_off = 1'b0;

    // software copy of the config and the gate state
    bit            gate_en = 1'b1;
    logic [CB-1:0] coef_cfg [ngh_pkg::NUM_REGS] = '{24'd0, 24'd216765, 24'd4952960,
                                                    24'd231405, 24'd1589, 24'd345890,
                                                    24'd1942};
    longint        hl_state = 0;
    longint        lp_state = 0;
    longint        env_state = 0;
    bit            flag_open = 1'b0;
    longint        gain_state = 0;

    noise_gate_hysteresis #(
        .SAMPLE_BITS(SB),
        .COEFF_BITS (CB)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sidechain_sample(i_sidechain_sample),
        .i_audio_sample    (i_audio_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_gated_sample    (o_gated_sample),
        .o_gate_open       (o_gate_open),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // round(a * b / 2^CB), ties up, exact product
    function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b} + (128'd1 << (CB - 1));
        return prod[CB +: 64];
    endfunction

    // magnitude rounded, sign put back
    function automatic longint coef_mul(logic [CB-1:0] c, longint d);
        longint unsigned mag;
        longint unsigned p;
        mag = (d < 0) ? -d : d;
        p = mul_round(c, mag);
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_gated gate_step(logic signed [SB-1:0] sc, logic signed [SB-1:0] au);
        longint s;
        longint a;
        longint res;
        longint hp;
        longint mag;
        longint target;
        logic [CB-1:0] rate;
        longint unsigned gm;
        t_gated r;
        s = sc;
        a = au;
        res = a;
        if (gate_en) begin
            hl_state += coef_mul(coef_cfg[ngh_pkg::REG_HP_COEFF], s - hl_state);
            hp = s - hl_state;
            lp_state += coef_mul(coef_cfg[ngh_pkg::REG_LP_COEFF], hp - lp_state);
            mag = (lp_state < 0) ? -lp_state : lp_state;
            if (mag > SMASK) mag = SMASK;
            rate = (mag > env_state) ? coef_cfg[ngh_pkg::REG_ENV_ATTACK]
                                     : coef_cfg[ngh_pkg::REG_ENV_RELEASE];
            env_state += coef_mul(rate, mag - env_state);
            if (!flag_open) begin
                flag_open = (env_state >= THR_OPEN);
            end else if (env_state < THR_CLOSE) begin
                flag_open = 1'b0;
            end
            target = flag_open ? UNITY : 0;
            rate = (target > gain_state) ? coef_cfg[ngh_pkg::REG_GAIN_ATTACK]
                                         : coef_cfg[ngh_pkg::REG_GAIN_RELEASE];
            gain_state += coef_mul(rate, target - gain_state);
            gm = mul_round(gain_state, (a < 0) ? -a : a);
            res = (a < 0) ? -longint'(gm) : longint'(gm);
        end
        r.gated = res[SB-1:0];
        r.is_open = flag_open;
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    // input side: hold payload until taken, then maybe gap
    always @(posedge i_clk) begin : drive_in
        t_gate_in nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                gated_fifo.push_back(gate_step(i_sidechain_sample, i_audio_sample));
            end
            if (!i_in_valid || o_in_ready) begin
                if (item_q.size() != 0 && !(in_gaps_on && $urandom_range(0, 99) < 24)) begin
                    nxt = item_q.pop_front();
                    i_sidechain_sample <= nxt.sc;
                    i_audio_sample <= nxt.audio;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_gated want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (gated_fifo.size() == 0) begin
                    note_mismatch($sformatf("result %0d/%0b with no item pending",
                                            o_gated_sample, o_gate_open));
                end else begin
                    want = gated_fifo.pop_front();
                    if (o_gated_sample !== want.gated || o_gate_open !== want.is_open) begin
                        note_mismatch($sformatf("gated %0d gate_open %0b, expected %0d %0b",
                                                o_gated_sample, o_gate_open,
                                                want.gated, want.is_open));
                    end
                end
            end
            i_out_ready <= !hold_off && !(out_gaps_on && $urandom_range(0, 99) < 24);
        end
    end

    task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= AW'(idx * 4);
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_write(input int idx, input logic [31:0] data);
        logic [31:0] unused;
        apb_access(1'b1, idx, data, unused);
        // out-of-range index: dropped
        if (idx == ngh_pkg::REG_GATE_ENABLE) begin
            gate_en = data[0];
        end else if (idx < ngh_pkg::NUM_REGS) begin
            coef_cfg[idx] = data[CB-1:0];
        end
    endtask

    task automatic regs_readback();
        logic [31:0] got;
        logic [31:0] want;
        for (int idx = 0; idx < ngh_pkg::NUM_REGS; idx++) begin
            apb_access(1'b0, idx, 32'd0, got);
            want = (idx == ngh_pkg::REG_GATE_ENABLE) ? {31'd0, gate_en} : {8'd0, coef_cfg[idx]};
            if (got !== want) begin
                note_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
            end
        end
    endtask

    task automatic add_item(input logic signed [SB-1:0] sc, input logic signed [SB-1:0] au);
        item_q.push_back('{sc, au});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (item_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (gated_fifo.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coeff();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       v[CB-1:0] = '0;
            1, 2:    v[CB-1:0] = '1;
            3, 4, 5: v[CB-1:0] = CB'($urandom_range(0, 16383));
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_config();
        logic [31:0] v;
        v = $urandom();
        v[0] = ($urandom_range(0, 5) != 0);
        reg_write(ngh_pkg::REG_GATE_ENABLE, v);
        for (int idx = ngh_pkg::REG_HP_COEFF; idx <= ngh_pkg::REG_GAIN_RELEASE; idx++) begin
            reg_write(idx, pick_coeff());
        end
    endtask

    // bursts of one loudness class: silence, near threshold, loud, or noise
    task automatic add_bursts(input int n);
        int left;
        int len;
        int level;
        int amp;
        logic signed [SB-1:0] sc;
        logic signed [SB-1:0] au;
        left = n;
        while (left > 0) begin
            level = $urandom_range(0, 3);
            len = $urandom_range(3, 30);
            if (len > left) len = left;
            repeat (len) begin
                case (level)
                    0: sc = SB'(int'($urandom_range(0, 400)) - 200);
                    1: begin
                        amp = $urandom_range(1000, 30000);
                        sc = $urandom_range(0, 1) ? SB'(amp) : SB'(-amp);
                    end
                    2: sc = SB'($urandom());
                    default: begin
                        case ($urandom_range(0, 3))
                            0: sc = S_MAX;
                            1: sc = S_MIN;
                            2: sc = '0;
                            default: sc = SB'($urandom());
                        endcase
                    end
                endcase
                if ($urandom_range(0, 15) == 0) begin
                    au = $urandom_range(0, 1) ? S_MAX : S_MIN;
                end else begin
                    au = SB'($urandom());
                end
                add_item(sc, au);
            end
            left -= len;
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then extremes; alternating full scale opens the gate
        regs_readback();
        add_item('0, '0);
        add_item('0, S_MAX);
        add_item(S_MAX, S_MIN);
        add_item(S_MIN, S_MAX);
        add_item(S_MAX, -24'sd1);
        add_item(S_MIN, 24'sd1);
        add_item(S_MAX, S_MAX);
        add_item(S_MIN, S_MIN);
        wait_idle();

        // bypass: audio passes, detector frozen
        reg_write(ngh_pkg::REG_GATE_ENABLE, 32'hFFFF_FFFE);
        regs_readback();
        add_item(S_MAX, S_MAX);
        add_item(S_MIN, S_MIN);
        add_item('0, -24'sd1);
        wait_idle();
        reg_write(ngh_pkg::REG_GATE_ENABLE, 32'd1);

        // full-scale coefficients, upper bits dropped; bad index ignored
        for (int idx = ngh_pkg::REG_HP_COEFF; idx <= ngh_pkg::REG_GAIN_RELEASE; idx++) begin
            reg_write(idx, 32'hFFFF_FFFF);
        end
        reg_write(ngh_pkg::NUM_REGS, 32'h0000_1234);
        regs_readback();
        repeat (3) add_item(S_MAX, 24'sd1000);
        wait_idle();

        // high-pass low part parked at max: largest detector swing, then silence
        reg_write(ngh_pkg::REG_HP_COEFF, 32'd0);
        add_item(S_MIN, S_MAX);
        add_item(S_MIN, S_MIN);
        add_item('0, S_MAX);
        add_item('0, S_MIN);
        add_item('0, '0);
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            random_config();
            regs_readback();
            in_gaps_on = (ph != 0);
            out_gaps_on = (ph != 0);
            if (ph == 4) begin
                add_bursts(34);
                wait_idle();
                add_bursts(34);
            end else begin
                add_bursts(68);
            end
            if (ph == 2) begin
                // long receiver stall so the block backs up
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && gated_fifo.size() == 0) begin
            $display("noise_gate_hysteresis_test OK");
        end else begin
            if (gated_fifo.size() != 0) begin
                $display("%0d results never arrived", gated_fifo.size());
            end
            $display("noise_gate_hysteresis_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout");
        $display("noise_gate_hysteresis_test NOT OK");
        $finish;
    end

endmodule
